@@ design/assert_macros.svh @@
// Shared assertion forms for the parser checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, muted while reset is low.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, muted while reset is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/hctp_pkg.sv @@
`default_nettype none

package hctp_pkg;

	localparam int unsigned VALUE_BITS_DEF = 32;
	localparam int unsigned OUT_BITS       = 32;

	// scan position inside the current part of a token
	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_SIGNED = 3'd1,
		PH_DONE   = 3'd2,
		PH_ZERO   = 3'd3,
		PH_PREFIX = 3'd4,
		PH_DIGITS = 3'd5
	} phase_t;

	typedef struct packed {
		logic       is_sep;
		logic       is_digit;
		logic       is_hex;
		logic [3:0] nibble;
		logic       is_plus;
		logic       is_minus;
		logic       is_comma;
		logic       is_zero;
		logic       is_x;
	} char_class_t;

	typedef struct packed {
		logic   token_open;
		logic   comma_seen;
		phase_t phase;
		logic   height_neg;
		logic   color_neg;
	} token_ctl_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] height;
		logic                       has_color;
		logic signed [OUT_BITS-1:0] color;
		logic                       line_end;
	} result_t;

	localparam token_ctl_t CTL_CLEAR = '{
		token_open: 1'b0,
		comma_seen: 1'b0,
		phase:      PH_START,
		height_neg: 1'b0,
		color_neg:  1'b0
	};

endpackage

`default_nettype wire

@@ design/hctp_char_decode.sv @@
`default_nettype none

module hctp_char_decode import hctp_pkg::*; (
	input  logic [7:0]  ch,
	output char_class_t cls
);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A_UP  = 8'h41;
	localparam logic [7:0] CH_F_UP  = 8'h46;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_F_LO  = 8'h66;
	localparam logic [7:0] CH_X_LO  = 8'h78;

	logic is_letter;

	always_comb begin
		cls.is_sep   = (ch == CH_NUL) || (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
		cls.is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
		is_letter    = (ch >= CH_A_LO && ch <= CH_F_LO) || (ch >= CH_A_UP && ch <= CH_F_UP);
		cls.is_hex   = cls.is_digit || is_letter;
		// 'a'/'A' have low nibble 1, so letters map to low nibble + 9
		cls.nibble   = cls.is_digit ? ch[3:0] : ch[3:0] + 4'd9;
		cls.is_plus  = (ch == CH_PLUS);
		cls.is_minus = (ch == CH_MINUS);
		cls.is_comma = (ch == CH_COMMA);
		cls.is_zero  = (ch == CH_ZERO);
		cls.is_x     = (ch == CH_X_LO) || (ch == CH_X_UP);
	end

endmodule

`default_nettype wire

@@ design/hctp_token_step.sv @@
`default_nettype none

module hctp_token_step import hctp_pkg::*; #(
	parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
	input  token_ctl_t            ctl,
	input  logic [VALUE_BITS-1:0] h_acc,
	input  logic [VALUE_BITS-1:0] c_acc,
	input  char_class_t           cls,
	input  logic                  eol,
	output token_ctl_t            ctl_nxt,
	output logic [VALUE_BITS-1:0] h_acc_nxt,
	output logic [VALUE_BITS-1:0] c_acc_nxt,
	output logic                  emit,
	output result_t               res
);

	token_ctl_t                   ctl_w;
	logic [VALUE_BITS-1:0]        h_w;
	logic [VALUE_BITS-1:0]        c_w;
	logic [VALUE_BITS-1:0]        h_mul;
	logic [VALUE_BITS-1:0]        c_shift;
	logic signed [VALUE_BITS-1:0] h_fin;
	logic signed [VALUE_BITS-1:0] c_fin;

	// acc*10 + digit, and acc*16 + nibble, both wrapping
	assign h_mul   = (h_acc << 3) + (h_acc << 1) + VALUE_BITS'(cls.nibble);
	assign c_shift = {c_acc[VALUE_BITS-5:0], cls.nibble};

	always_comb begin
		ctl_w = ctl;
		h_w   = h_acc;
		c_w   = c_acc;
		if (!cls.is_sep) begin
			ctl_w.token_open = 1'b1;
			if (!ctl.comma_seen && cls.is_comma) begin
				ctl_w.comma_seen = 1'b1;
				ctl_w.phase      = PH_START;
			end else if (ctl.comma_seen) begin
				// color: sign, optional 0x, hex digits
				unique case (ctl.phase)
					PH_START: begin
						if (cls.is_plus || cls.is_minus) begin
							ctl_w.color_neg = cls.is_minus;
							ctl_w.phase     = PH_SIGNED;
						end else if (cls.is_zero) begin
							ctl_w.phase = PH_ZERO;
						end else if (cls.is_hex) begin
							c_w         = c_shift;
							ctl_w.phase = PH_DIGITS;
						end else begin
							ctl_w.phase = PH_DONE;
						end
					end
					PH_SIGNED: begin
						if (cls.is_zero) begin
							ctl_w.phase = PH_ZERO;
						end else if (cls.is_hex) begin
							c_w         = c_shift;
							ctl_w.phase = PH_DIGITS;
						end else begin
							ctl_w.phase = PH_DONE;
						end
					end
					PH_ZERO: begin
						if (cls.is_x) begin
							ctl_w.phase = PH_PREFIX;
						end else if (cls.is_hex) begin
							c_w         = c_shift;
							ctl_w.phase = PH_DIGITS;
						end else begin
							ctl_w.phase = PH_DONE;
						end
					end
					PH_PREFIX, PH_DIGITS: begin
						if (cls.is_hex) begin
							c_w         = c_shift;
							ctl_w.phase = PH_DIGITS;
						end else begin
							ctl_w.phase = PH_DONE;
						end
					end
					default: begin
						ctl_w.phase = ctl.phase;
					end
				endcase
			end else if (ctl.phase != PH_DONE) begin
				// height: sign, then decimal digits
				priority if (cls.is_digit) begin
					h_w         = h_mul;
					ctl_w.phase = PH_SIGNED;
				end else if (ctl.phase == PH_START && (cls.is_plus || cls.is_minus)) begin
					ctl_w.height_neg = cls.is_minus;
					ctl_w.phase      = PH_SIGNED;
				end else begin
					ctl_w.phase = PH_DONE;
				end
			end
		end
	end

	assign emit  = (cls.is_sep || eol) && ctl_w.token_open;
	assign h_fin = ctl_w.height_neg ? -h_w : h_w;
	assign c_fin = ctl_w.color_neg ? -c_w : c_w;

	always_comb begin
		res.height    = OUT_BITS'(h_fin);
		res.has_color = ctl_w.comma_seen;
		res.color     = ctl_w.comma_seen ? OUT_BITS'(c_fin) : '1;
		res.line_end  = eol;
		if (emit) begin
			ctl_nxt   = CTL_CLEAR;
			h_acc_nxt = '0;
			c_acc_nxt = '0;
		end else begin
			ctl_nxt   = ctl_w;
			h_acc_nxt = h_w;
			c_acc_nxt = c_w;
		end
	end

endmodule

`default_nettype wire

@@ design/height_color_token_parser.sv @@
// A byte taken in is registered in stage 1 and decoded there; a token it
// closes shows on the result port from the stage-2 register (out_valid high).
// Throughput: one byte per cycle; the input stalls only while a closing
// byte waits behind an untaken result. Set by the one-byte token update.
// Reset (arst_n low, async): token state, accumulators and valid flags clear.
`default_nettype none

module height_color_token_parser import hctp_pkg::*; #(
	parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 char_byte,
	input  logic                       end_of_line,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [OUT_BITS-1:0] height_value,
	output logic                       has_color,
	output logic signed [OUT_BITS-1:0] color_value,
	output logic                       line_end
);

	// Stage 1: registered input beat.
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eol_s1;

	// Token state carried from byte to byte.
	token_ctl_t            ctl_q;
	logic [VALUE_BITS-1:0] h_acc_q;
	logic [VALUE_BITS-1:0] c_acc_q;

	// Stage 2: result register.
	logic    valid_s2;
	result_t res_s2;

	char_class_t           cls;
	token_ctl_t            ctl_nxt;
	logic [VALUE_BITS-1:0] h_acc_nxt;
	logic [VALUE_BITS-1:0] c_acc_nxt;
	logic                  emit;
	result_t               res;
	logic                  advance;
	logic                  take_in;

	hctp_char_decode u_decode (
		.ch  (char_s1),
		.cls (cls)
	);

	hctp_token_step #(
		.VALUE_BITS (VALUE_BITS)
	) u_step (
		.ctl       (ctl_q),
		.h_acc     (h_acc_q),
		.c_acc     (c_acc_q),
		.cls       (cls),
		.eol       (eol_s1),
		.ctl_nxt   (ctl_nxt),
		.h_acc_nxt (h_acc_nxt),
		.c_acc_nxt (c_acc_nxt),
		.emit      (emit),
		.res       (res)
	);

	// The stage-1 byte moves on unless it closes a token while the result
	// register still holds an untaken beat. Bytes that close nothing never wait.
	assign advance  = valid_s1 && (!emit || !valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign take_in  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			char_s1 <= char_byte;
			eol_s1  <= end_of_line;
		end
	end

	// Token state commits only when the stage-1 byte is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q   <= CTL_CLEAR;
			h_acc_q <= '0;
			c_acc_q <= '0;
		end else if (advance) begin
			ctl_q   <= ctl_nxt;
			h_acc_q <= h_acc_nxt;
			c_acc_q <= c_acc_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && emit) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign height_value = res_s2.height;
	assign has_color    = res_s2.has_color;
	assign color_value  = res_s2.color;
	assign line_end     = res_s2.line_end;

endmodule

`default_nettype wire

@@ design/hctp_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module hctp_checker import hctp_pkg::*; (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic [7:0]                 char_byte,
	input wire logic                       end_of_line,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic signed [OUT_BITS-1:0] height_value,
	input wire logic                       has_color,
	input wire logic signed [OUT_BITS-1:0] color_value,
	input wire logic                       line_end
);

	logic [2*OUT_BITS+1:0] out_beat;
	logic                  in_beat;

	assign out_beat = {height_value, has_color, color_value, line_end};
	assign in_beat  = in_valid && in_ready;

	// untaken result beat holds
	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_beat), "stalled beat changed")

	// no comma means color reads as all ones
	`ASSERT_IMPL(a_no_color_ones, out_valid && !has_color, color_value == '1, "color not -1 without comma")

	// with the result register empty, the input side never stalls
	`ASSERT_IMPL(a_ready_when_empty, !out_valid, in_ready, "input stalled while empty")

	// a fresh result follows an input beat taken through stage 1 and the result register
	`ASSERT_IMPL(a_latency, out_valid && !$past(out_valid), $past(in_beat, 2), "result w/o input beat")

endmodule

bind height_color_token_parser hctp_checker u_hctp_checker (.*);

`default_nettype wire

@@ tb/sv/token_result_check.sv @@
`timescale 1ns / 100ps

module token_result_check import hctp_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [7:0]                 char_byte,
	input  logic                       end_of_line,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic signed [OUT_BITS-1:0] height_value,
	input  logic                       has_color,
	input  logic signed [OUT_BITS-1:0] color_value,
	input  logic                       line_end,
	output int                         fail_count,
	output int                         pending_tokens,
	output int                         tokens_checked
);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_F = 8'h66;
	localparam logic [7:0] CH_LOW_X = 8'h78;

	logic                tok_open;
	logic                comma_seen;
	logic                height_neg;
	logic                color_neg;
	phase_t              scan_phase;
	logic [OUT_BITS-1:0] height_acc;
	logic [OUT_BITS-1:0] color_acc;
	result_t             expected_tokens[$];

	function automatic logic is_separator(input logic [7:0] c);
		return c == CH_NUL || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
		if (c >= CH_LOW_A && c <= CH_LOW_F) return int'(c - CH_LOW_A) + 10;
		if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
		return -1;
	endfunction

	task clear_token();
		tok_open   = 1'b0;
		comma_seen = 1'b0;
		height_neg = 1'b0;
		color_neg  = 1'b0;
		scan_phase = PH_START;
		height_acc = '0;
		color_acc  = '0;
	endtask

	// decimal part: sign, then digits until the first non-digit
	task take_height_byte(input logic [7:0] c);
		if (scan_phase != PH_DONE) begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				height_acc = height_acc * 10 + (c - CH_ZERO);
				scan_phase = PH_SIGNED;
			end else if (scan_phase == PH_START && (c == CH_PLUS || c == CH_MINUS)) begin
				height_neg = (c == CH_MINUS);
				scan_phase = PH_SIGNED;
			end else begin
				scan_phase = PH_DONE;
			end
		end
	endtask

	// hex part: sign, optional 0x/0X, then hex digits
	task take_color_byte(input logic [7:0] c);
		int   d;
		logic as_digit;
		d        = hex_digit(c);
		as_digit = 1'b0;
		case (scan_phase)
			PH_START: begin
				if (c == CH_PLUS || c == CH_MINUS) begin
					color_neg  = (c == CH_MINUS);
					scan_phase = PH_SIGNED;
				end else if (c == CH_ZERO) begin
					scan_phase = PH_ZERO;
				end else begin
					as_digit = 1'b1;
				end
			end
			PH_SIGNED: begin
				if (c == CH_ZERO) scan_phase = PH_ZERO;
				else as_digit = 1'b1;
			end
			PH_ZERO: begin
				if (c == CH_LOW_X || c == CH_UP_X) scan_phase = PH_PREFIX;
				else as_digit = 1'b1;
			end
			PH_PREFIX, PH_DIGITS: as_digit = 1'b1;
			default: ;
		endcase
		if (as_digit) begin
			if (d >= 0) begin
				color_acc  = {color_acc[OUT_BITS-5:0], 4'(d)};
				scan_phase = PH_DIGITS;
			end else begin
				scan_phase = PH_DONE;
			end
		end
	endtask

	task parse_byte(input logic [7:0] c, input logic eol);
		result_t r;
		logic    sep;
		sep = is_separator(c);
		if (!sep) begin
			tok_open = 1'b1;
			if (!comma_seen && c == CH_COMMA) begin
				comma_seen = 1'b1;
				scan_phase = PH_START;
			end else if (comma_seen) begin
				take_color_byte(c);
			end else begin
				take_height_byte(c);
			end
		end
		if ((sep || eol) && tok_open) begin
			r.height    = height_neg ? -height_acc : height_acc;
			r.has_color = comma_seen;
			r.color     = !comma_seen ? '1 : (color_neg ? -color_acc : color_acc);
			r.line_end  = eol;
			expected_tokens.push_back(r);
			clear_token();
		end
	endtask

	task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch on token %0d, %s: got %h, want %h",
			$realtime, tokens_checked, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			clear_token();
			expected_tokens.delete();
			fail_count     = 0;
			tokens_checked = 0;
			pending_tokens <= 0;
		end else begin
			if (in_valid && in_ready === 1'b1)
				parse_byte(char_byte, end_of_line);
			if (out_valid === 1'b1 && out_ready) begin
				if (expected_tokens.size() == 0) begin
					report_mismatch("result beat with none pending", height_value, '0);
				end else begin
					want = expected_tokens.pop_front();
					tokens_checked++;
					if (height_value !== want.height)
						report_mismatch("height_value", height_value, want.height);
					if (has_color !== want.has_color)
						report_mismatch("has_color", 32'(has_color), 32'(want.has_color));
					if (color_value !== want.color)
						report_mismatch("color_value", color_value, want.color);
					if (line_end !== want.line_end)
						report_mismatch("line_end", 32'(line_end), 32'(want.line_end));
				end
			end
			// published after the edge so the top samples a settled count
			pending_tokens <= expected_tokens.size();
		end
	end

endmodule

@@ tb/sv/height_color_token_parser_tb.sv @@
`timescale 1ns / 100ps

module height_color_token_parser_tb;
	import hctp_pkg::*;

	// rough count of random byte beats, split over the three traffic mixes
	localparam int RANDOM_BYTES     = 1150;
	// output side goes quiet this long once, so the parser backs up
	localparam int LONG_HOLD_CYCLES = 400;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_X = 8'h78;

	logic                       clk;
	logic                       arst_n      = 1'b0;
	logic                       in_valid    = 1'b0;
	logic [7:0]                 char_byte   = '0;
	logic                       end_of_line = 1'b0;
	logic                       out_ready   = 1'b0;
	logic                       in_ready;
	logic                       out_valid;
	logic signed [OUT_BITS-1:0] height_value;
	logic                       has_color;
	logic signed [OUT_BITS-1:0] color_value;
	logic                       line_end;

	int fail_count;
	int pending_tokens;
	int tokens_checked;

	// traffic mix: receiver-heavy idling, then sender-heavy, then none
	int send_idle_by_phase[3] = '{29, 72, 0};
	int recv_idle_by_phase[3] = '{72, 29, 0};
	int traffic_phase = 0;
	int send_idle_pct = 29;
	int recv_idle_pct = 72;
	int bytes_sent    = 0;
	int directed_end  = 0;

	// beats of the token being sent: bit 8 is end_of_line, 7:0 the byte
	logic [8:0] token_beats[$];

	height_color_token_parser dut (.*);

	token_result_check result_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// the seven token separators: NUL, space and TAB..CR, for n = 0..6
	function automatic logic [7:0] sep_char(input int unsigned n);
		return (n == 0) ? 8'h00 : (n == 1) ? CH_SPACE : 8'(CH_TAB + n - 2);
	endfunction

	task automatic add_beat(input logic [7:0] c, input logic eol);
		token_beats.push_back({eol, c});
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_beat(s[i], 1'b0);
	endtask

	// One byte beat. Random idle cycles go in front of the beat only, so
	// once valid rises it holds with a steady payload until the handshake.
	task automatic send_beat(input logic [7:0] c, input logic eol);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		char_byte   <= c;
		end_of_line <= eol;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_token_beats();
		foreach (token_beats[i])
			send_beat(token_beats[i][7:0], token_beats[i][8]);
		token_beats.delete();
	endtask

	// Mostly well-formed "height,color" tokens with random content; the
	// rest is raw noise. Long digit runs push both values past 32 bits.
	task automatic build_random_token();
		int unsigned n;
		int unsigned d;
		token_beats.delete();
		if ($urandom_range(99) < 15) begin
			// noise: any byte value, separators and commas included
			n = $urandom_range(1, 6);
			repeat (n) add_beat(8'($urandom_range(255)), 1'b0);
		end else begin
			case ($urandom_range(3))
				1: add_beat(CH_PLUS, 1'b0);
				2: add_beat(CH_MINUS, 1'b0);
				default: ;
			endcase
			n = ($urandom_range(9) < 2) ? $urandom_range(10, 14) : $urandom_range(0, 5);
			repeat (n) add_beat(8'(CH_ZERO + $urandom_range(9)), 1'b0);
			// stray byte not a digit, comma or leading sign stops the height; digits after are dead
			if ($urandom_range(7) == 0) begin
				add_beat(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
				add_beat(8'(CH_ZERO + $urandom_range(9)), 1'b0);
			end
			if ($urandom_range(3) != 0) begin
				add_beat(CH_COMMA, 1'b0);
				case ($urandom_range(3))
					1: add_beat(CH_PLUS, 1'b0);
					2: add_beat(CH_MINUS, 1'b0);
					default: ;
				endcase
				if ($urandom_range(1)) begin
					add_beat(CH_ZERO, 1'b0);
					add_beat($urandom_range(1) ? CH_LOW_X : CH_UP_X, 1'b0);
				end
				n = ($urandom_range(9) < 2) ? $urandom_range(9, 12) : $urandom_range(0, 6);
				repeat (n) begin
					d = $urandom_range(21);
					add_beat((d < 10) ? 8'(CH_ZERO + d) :
						(d < 16) ? 8'(CH_LOW_A + d - 10) : 8'(CH_UP_A + d - 16), 1'b0);
				end
				// a second comma is just text inside the color part
				if ($urandom_range(5) == 0) begin
					add_beat(CH_COMMA, 1'b0);
					add_beat(8'(CH_ZERO + $urandom_range(9)), 1'b0);
				end
			end
		end
		// close on the line-end mark or on a separator (itself maybe end of line)
		if (token_beats.size() != 0 && $urandom_range(3) == 0)
			token_beats[token_beats.size() - 1][8] = 1'b1;
		else
			add_beat(sep_char($urandom_range(5)), 1'($urandom_range(1)));
		// extra separator with nothing open must stay silent
		if ($urandom_range(4) == 0)
			add_beat(sep_char($urandom_range(5)), 1'($urandom_range(1)));
	endtask

	// Result side. Random back-pressure per the current traffic mix, plus
	// one long hold-off at the start of the free-flowing mix, counted here.
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (traffic_phase == 2 && !hold_done) begin
				hold_left = LONG_HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Byte side: reset, directed tokens, three random traffic mixes, drain.
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone separator carrying the line-end mark: nothing may come out
		add_beat(CH_SPACE, 1'b1);
		// sign with no digits, then an empty color after the comma
		add_text("-,");
		add_beat(CH_SPACE, 1'b0);
		// height stops at the letter; color is a bare 0x prefix
		add_text("9a9,+0x");
		add_beat(CH_TAB, 1'b0);
		// nine hex digits wrap the color; a later comma ends the scan; NUL closes
		add_text("7,-Ffc012345,");
		add_beat(8'h00, 1'b0);
		// top byte value is token text; line-end on it closes the token
		add_beat(8'hFF, 1'b1);
		send_token_beats();
		directed_end = bytes_sent;

		for (int p = 0; p < 3; p++) begin
			traffic_phase = p;
			send_idle_pct = send_idle_by_phase[p];
			recv_idle_pct = recv_idle_by_phase[p];
			while (bytes_sent < directed_end + (p + 1) * RANDOM_BYTES / 3) begin
				build_random_token();
				send_token_beats();
			end
		end
		in_valid <= 1'b0;

		// the count from the checker is registered, so it trails the beat
		@(posedge clk);
		while (pending_tokens != 0) @(posedge clk);
		// wait on to catch a stray result beat
		repeat (10) @(posedge clk);

		$display("Run covered %0d byte beats (%0d directed) under sender-heavy, receiver-heavy",
			bytes_sent, directed_end);
		$display("and free-flowing traffic with a %0d-cycle result stall; %0d tokens compared.",
			LONG_HOLD_CYCLES, tokens_checked);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("timeout with %0d tokens still pending", pending_tokens);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
